[rtl/ptc_pkg.sv]
`timescale 1ns / 1ps

package ptc_pkg;

   // Field widths
   localparam int SAMPLE_W = 10;
   localparam int DUTY_W   = 10;
   localparam int REG_W    = 16;
   localparam int BTN_W    = 4;

   // Working widths inside the datapath
   localparam int TEMP_W   = 12;   // -150 .. 1128
   localparam int QUOT_W   = 13;   // -3276 .. 3276
   localparam int ERR_W    = 14;   // -4404 .. 3426
   localparam int HEAT_W   = REG_W + ERR_W;

   // Button bit positions, in the order they are handled
   localparam int BTN_COARSE_UP   = 0;
   localparam int BTN_COARSE_DOWN = 1;
   localparam int BTN_FINE_UP     = 2;
   localparam int BTN_TOGGLE      = 3;

   // Reset values and steps
   localparam logic [REG_W-1:0] SETPOINT_RESET = 16'd4200;
   localparam logic [REG_W-1:0] GAIN_RESET     = 16'd90;
   localparam logic [REG_W-1:0] COARSE_STEP    = 16'd100;
   localparam logic [REG_W-1:0] FINE_STEP      = 16'd10;

   // Temperature offset and duty limit
   localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 12'sd150;
   localparam logic [DUTY_W-1:0]        DUTY_MAX    = 10'd1023;

   // Divide by ten: multiply by ceil(2^19 / 10), exact for 16-bit magnitudes
   localparam logic [REG_W-1:0] DIV10_RECIP = 16'd52429;
   localparam int               DIV10_SHIFT = 19;

   // Clamp a signed value to the duty range 0..1023
   function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [HEAT_W-1:0] v);
      logic [DUTY_W-1:0] res;
      if (v < 0) begin
         res = '0;
      end else if (v > $signed({{(HEAT_W-DUTY_W){1'b0}}, DUTY_MAX})) begin
         res = DUTY_MAX;
      end else begin
         res = v[DUTY_W-1:0];
      end
      return res;
   endfunction

endpackage

[rtl/ptc_req_if.sv]
`timescale 1ns / 1ps

interface ptc_req_if
   import ptc_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                btn_coarse_up;
   logic                btn_coarse_down;
   logic                btn_fine_up;
   logic                btn_toggle;
   logic [SAMPLE_W-1:0] temp_sample;
   logic [SAMPLE_W-1:0] cooler_sample;

   modport source (
      output valid, btn_coarse_up, btn_coarse_down, btn_fine_up, btn_toggle,
             temp_sample, cooler_sample,
      input  ready
   );

   modport sink (
      input  valid, btn_coarse_up, btn_coarse_down, btn_fine_up, btn_toggle,
             temp_sample, cooler_sample,
      output ready
   );
endinterface

[rtl/ptc_rsp_if.sv]
`timescale 1ns / 1ps

interface ptc_rsp_if
   import ptc_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [DUTY_W-1:0]        heater_duty;
   logic [DUTY_W-1:0]        cooler_duty;
   logic [DUTY_W-1:0]        temperature_shown;
   logic signed [REG_W-1:0]  setpoint_now;
   logic signed [REG_W-1:0]  gain_now;
   logic                     editing_gain;

   modport source (
      output valid, heater_duty, cooler_duty, temperature_shown, setpoint_now,
             gain_now, editing_gain,
      input  ready
   );

   modport sink (
      input  valid, heater_duty, cooler_duty, temperature_shown, setpoint_now,
             gain_now, editing_gain,
      output ready
   );
endinterface

[rtl/proportional_temperature_controller.sv]
`timescale 1ns / 1ps

// Channel   | Modport | Moves
// ----------+---------+-----------------------------------------------------
// req_chan  | sink    | button levels, temperature and cooler samples
// rsp_chan  | source  | heater/cooler duty, temperature, setpoint, gain, mode
//
// One request per cycle sustained while the result side takes results; each
// accepted request passes the state update, the divide-by-ten multiply, then
// the gain multiply into the result register.
// The gain multiply between the second stage and the result register sets
// the clock limit.
// Synchronous active-high reset: setpoint 4200, gain 90, gain editing, no
// buttons held, pipeline empty.
// Each stage moves on when the next one is empty or moving, so a stalled
// result still lets up to two further requests in.

module proportional_temperature_controller
   import ptc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   ptc_req_if.sink    req_chan,
   ptc_rsp_if.source  rsp_chan
);

   // Controller state, also the stage-one payload
   logic [BTN_W-1:0]    btn_prev_ff, btn_prev_in;
   logic [REG_W-1:0]    setpoint_ff, setpoint_in;
   logic [REG_W-1:0]    gain_ff, gain_in;
   logic                sel_gain_ff, sel_gain_in;
   logic [SAMPLE_W-1:0] temp_sample_ff;
   logic [SAMPLE_W-1:0] cooler_sample_ff;
   logic                s1_valid_ff, s1_valid_in;

   // Stage two
   logic signed [TEMP_W-1:0] temp_ff;
   logic signed [QUOT_W-1:0] quot_ff;
   logic signed [REG_W-1:0]  s2_gain_ff;
   logic [REG_W-1:0]         s2_setpoint_ff;
   logic                     s2_sel_gain_ff;
   logic [SAMPLE_W-1:0]      s2_cooler_ff;
   logic                     s2_valid_ff, s2_valid_in;

   // Result register
   logic                     rsp_valid_ff, rsp_valid_in;

   // Stage enables
   logic s1_en, s2_en, s3_en;
   logic req_accept;

   assign s3_en      = !rsp_valid_ff || rsp_chan.ready;
   assign s2_en      = !s2_valid_ff || s3_en;
   assign s1_en      = !s1_valid_ff || s2_en;
   assign req_accept = req_chan.valid && s1_en;

   assign req_chan.ready = s1_en;
   assign rsp_chan.valid = rsp_valid_ff;

   // Button edges and register adjust
   logic [BTN_W-1:0] btn_now;
   logic [BTN_W-1:0] btn_rise;
   logic [REG_W-1:0] delta;
   logic [REG_W-1:0] adjusted;

   assign btn_now  = {req_chan.btn_toggle, req_chan.btn_fine_up,
                      req_chan.btn_coarse_down, req_chan.btn_coarse_up};
   assign btn_rise = btn_now & ~btn_prev_ff;

   always_comb begin
      delta = '0;
      if (btn_rise[BTN_COARSE_UP]) begin
         delta = delta + COARSE_STEP;
      end
      if (btn_rise[BTN_COARSE_DOWN]) begin
         delta = delta - COARSE_STEP;
      end
      if (btn_rise[BTN_FINE_UP]) begin
         delta = delta + FINE_STEP;
      end
      adjusted = (sel_gain_ff ? gain_ff : setpoint_ff) + delta;
   end

   // State next values; toggle acts after the adjusts
   always_comb begin
      btn_prev_in = btn_prev_ff;
      setpoint_in = setpoint_ff;
      gain_in     = gain_ff;
      sel_gain_in = sel_gain_ff;
      if (req_accept) begin
         btn_prev_in = btn_now;
         if (sel_gain_ff) begin
            gain_in = adjusted;
         end else begin
            setpoint_in = adjusted;
         end
         sel_gain_in = sel_gain_ff ^ btn_rise[BTN_TOGGLE];
      end
   end

   assign s1_valid_in  = s1_en ? req_chan.valid : s1_valid_ff;
   assign s2_valid_in  = s2_en ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = s3_en ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         btn_prev_ff  <= '0;
         setpoint_ff  <= SETPOINT_RESET;
         gain_ff      <= GAIN_RESET;
         sel_gain_ff  <= 1'b1;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         btn_prev_ff  <= btn_prev_in;
         setpoint_ff  <= setpoint_in;
         gain_ff      <= gain_in;
         sel_gain_ff  <= sel_gain_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         temp_sample_ff   <= req_chan.temp_sample;
         cooler_sample_ff <= req_chan.cooler_sample;
      end
   end

   // Stage two: scaled temperature and setpoint / 10 toward zero
   logic [SAMPLE_W+3:0]       temp_x10;
   logic signed [TEMP_W-1:0]  temp_calc;
   logic                      sp_neg;
   logic [REG_W-1:0]          sp_mag;
   logic [2*REG_W-1:0]        recip_prod;
   logic [QUOT_W-2:0]         quot_mag;
   logic signed [QUOT_W-1:0]  quot_calc;

   always_comb begin
      temp_x10   = {4'b0, temp_sample_ff} * 14'd10;
      temp_calc  = $signed({1'b0, temp_x10[SAMPLE_W+3:3]}) - TEMP_OFFSET;
      sp_neg     = setpoint_ff[REG_W-1];
      sp_mag     = sp_neg ? (~setpoint_ff + 16'd1) : setpoint_ff;
      recip_prod = sp_mag * DIV10_RECIP;
      quot_mag   = recip_prod[DIV10_SHIFT +: (QUOT_W-1)];
      quot_calc  = sp_neg ? -$signed({1'b0, quot_mag}) : $signed({1'b0, quot_mag});
   end

   always_ff @(posedge clock) begin
      if (s2_en && s1_valid_ff) begin
         temp_ff        <= temp_calc;
         quot_ff        <= quot_calc;
         s2_gain_ff     <= $signed(gain_ff);
         s2_setpoint_ff <= setpoint_ff;
         s2_sel_gain_ff <= sel_gain_ff;
         s2_cooler_ff   <= cooler_sample_ff;
      end
   end

   // Stage three: error, gain product and clamps
   logic signed [ERR_W-1:0]  err;
   logic signed [HEAT_W-1:0] heat;

   always_comb begin
      err  = ERR_W'(quot_ff) - ERR_W'(temp_ff);
      heat = s2_gain_ff * err;
   end

   always_ff @(posedge clock) begin
      if (s3_en && s2_valid_ff) begin
         rsp_chan.heater_duty       <= clamp_duty(heat);
         rsp_chan.cooler_duty       <= s2_cooler_ff;
         rsp_chan.temperature_shown <= clamp_duty(HEAT_W'(temp_ff));
         rsp_chan.setpoint_now      <= $signed(s2_setpoint_ff);
         rsp_chan.gain_now          <= s2_gain_ff;
         rsp_chan.editing_gain      <= s2_sel_gain_ff;
      end
   end

`ifndef SYNTH
   // Reset loads the documented state
   assert property (@(posedge clock) reset |=>
      setpoint_ff == SETPOINT_RESET && gain_ff == GAIN_RESET && sel_gain_ff)
      else $error("state not at reset values after reset");

   // Without a request the controller state holds
   assert property (@(posedge clock) disable iff (reset) !req_accept |=>
      $stable(setpoint_ff) && $stable(gain_ff) && $stable(sel_gain_ff))
      else $error("controller state changed without a request");

   // Held buttons change neither setpoint nor gain
   assert property (@(posedge clock) disable iff (reset)
      req_accept && btn_rise == '0 |=> $stable(setpoint_ff) && $stable(gain_ff))
      else $error("setpoint or gain changed without a rising button");

   // A toggle edge flips the edit target
   assert property (@(posedge clock) disable iff (reset)
      req_accept && btn_rise[BTN_TOGGLE] |=> sel_gain_ff != $past(sel_gain_ff))
      else $error("toggle edge did not flip the edit target");
`endif

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top
   import ptc_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int MAX_REPORTS    = 10;

   // Button level masks, one bit per button in handling order
   localparam logic [BTN_W-1:0] LV_NONE   = '0;
   localparam logic [BTN_W-1:0] LV_UP     = BTN_W'(1) << BTN_COARSE_UP;
   localparam logic [BTN_W-1:0] LV_DOWN   = BTN_W'(1) << BTN_COARSE_DOWN;
   localparam logic [BTN_W-1:0] LV_FINE   = BTN_W'(1) << BTN_FINE_UP;
   localparam logic [BTN_W-1:0] LV_TOGGLE = BTN_W'(1) << BTN_TOGGLE;

   typedef struct packed {
      logic [BTN_W-1:0]    levels;
      logic [SAMPLE_W-1:0] temp_raw;
      logic [SAMPLE_W-1:0] cooler_raw;
   } loop_request_type;

   typedef struct packed {
      logic [DUTY_W-1:0]       heater;
      logic [DUTY_W-1:0]       cooler;
      logic [DUTY_W-1:0]       temp_shown;
      logic signed [REG_W-1:0] setpoint;
      logic signed [REG_W-1:0] gain;
      logic                    gain_edit;
   } loop_result_type;

   logic clock;
   logic reset;

   ptc_req_if req_if ();
   ptc_rsp_if rsp_if ();

   proportional_temperature_controller u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Controller state as predicted from accepted requests
   logic [BTN_W-1:0] held_levels;
   logic [REG_W-1:0] setpoint_tenths;
   logic [REG_W-1:0] gain_value;
   logic             gain_edit_sel;

   loop_result_type expected_results[$];
   loop_result_type seen_result;
   int              mismatch_count = 0;
   int              quiet_cycles   = 0;
   int              req_idle_pct;
   int              rsp_stall_pct;

   // What the stimulus side last sent, used to steer the register sweeps
   logic [BTN_W-1:0] sent_levels;
   logic             sent_gain_edit;

   always #4 clock = ~clock;

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------
   function automatic void step_edit_target(input logic [REG_W-1:0] delta);
      if (gain_edit_sel) begin
         gain_value = gain_value + delta;
      end else begin
         setpoint_tenths = setpoint_tenths + delta;
      end
   endfunction

   function automatic logic [DUTY_W-1:0] limit_duty(input longint v);
      if (v < 0) begin
         return '0;
      end
      if (v > longint'(DUTY_MAX)) begin
         return DUTY_MAX;
      end
      return v[DUTY_W-1:0];
   endfunction

   function automatic loop_result_type predict_loop_pass(input loop_request_type r);
      logic [BTN_W-1:0] rising;
      int               temp_c;
      int               err;
      longint           heat;
      loop_result_type  res;
      rising = r.levels & ~held_levels;
      // buttons act in order, the toggle last
      if (rising[BTN_COARSE_UP]) begin
         step_edit_target(COARSE_STEP);
      end
      if (rising[BTN_COARSE_DOWN]) begin
         step_edit_target(-COARSE_STEP);
      end
      if (rising[BTN_FINE_UP]) begin
         step_edit_target(FINE_STEP);
      end
      if (rising[BTN_TOGGLE]) begin
         gain_edit_sel = ~gain_edit_sel;
      end
      held_levels = r.levels;
      // error uses the unclamped temperature; divide truncates toward zero
      temp_c = int'(r.temp_raw) * 10 / 8 - int'(TEMP_OFFSET);
      err    = int'($signed(setpoint_tenths)) / 10 - temp_c;
      heat   = longint'($signed(gain_value)) * longint'(err);
      res.heater     = limit_duty(heat);
      res.cooler     = limit_duty(longint'(r.cooler_raw));
      res.temp_shown = limit_duty(longint'(temp_c));
      res.setpoint   = setpoint_tenths;
      res.gain       = gain_value;
      res.gain_edit  = gain_edit_sel;
      return res;
   endfunction

   // ---------------------------------------------------------------
   // Result checking and watchdog
   // ---------------------------------------------------------------
   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_levels     = '0;
         setpoint_tenths = SETPOINT_RESET;
         gain_value      = GAIN_RESET;
         gain_edit_sel   = 1'b1;
         quiet_cycles    = 0;
      end else begin
         // predict on every accepted request
         if (req_if.valid && req_if.ready) begin
            expected_results.push_back(predict_loop_pass('{
               levels:     {req_if.btn_toggle, req_if.btn_fine_up,
                            req_if.btn_coarse_down, req_if.btn_coarse_up},
               temp_raw:   req_if.temp_sample,
               cooler_raw: req_if.cooler_sample}));
         end
         // compare each accepted result with the oldest prediction
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: result with no request outstanding", $realtime);
               end
            end else begin
               seen_result = expected_results.pop_front();
               check_field("heater_duty", seen_result.heater, rsp_if.heater_duty);
               check_field("cooler_duty", seen_result.cooler, rsp_if.cooler_duty);
               check_field("temperature_shown", seen_result.temp_shown,
                           rsp_if.temperature_shown);
               check_field("setpoint_now", seen_result.setpoint, rsp_if.setpoint_now);
               check_field("gain_now", seen_result.gain, rsp_if.gain_now);
               check_field("editing_gain", seen_result.gain_edit, rsp_if.editing_gain);
            end
         end
         // watchdog: cycles with no handshake on either side
         if (!(req_if.valid && req_if.ready) && !(rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("[proportional_temperature_controller] ERROR");
               $finish;
            end
         end else begin
            quiet_cycles = 0;
         end
      end
   end

   // Result side back-pressure
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   function automatic loop_request_type make_request(input logic [BTN_W-1:0] levels,
                                                     input int temp_raw,
                                                     input int cooler_raw);
      loop_request_type r;
      r.levels     = levels;
      r.temp_raw   = temp_raw[SAMPLE_W-1:0];
      r.cooler_raw = cooler_raw[SAMPLE_W-1:0];
      return r;
   endfunction

   // Send one request; returns at the edge that accepts it
   task automatic send_request(input loop_request_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.btn_coarse_up   <= r.levels[BTN_COARSE_UP];
      req_if.btn_coarse_down <= r.levels[BTN_COARSE_DOWN];
      req_if.btn_fine_up     <= r.levels[BTN_FINE_UP];
      req_if.btn_toggle      <= r.levels[BTN_TOGGLE];
      req_if.temp_sample     <= r.temp_raw;
      req_if.cooler_sample   <= r.cooler_raw;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      if (r.levels[BTN_TOGGLE] && !sent_levels[BTN_TOGGLE]) begin
         sent_gain_edit = ~sent_gain_edit;
      end
      sent_levels = r.levels;
   endtask

   task automatic set_edit_target(input logic want_gain);
      if (sent_levels != LV_NONE) begin
         send_request(make_request(LV_NONE, $urandom_range(1023), $urandom_range(1023)));
      end
      if (sent_gain_edit != want_gain) begin
         send_request(make_request(LV_TOGGLE, $urandom_range(1023), $urandom_range(1023)));
         send_request(make_request(LV_NONE, $urandom_range(1023), $urandom_range(1023)));
      end
   endtask

   // Repeated press/release of one button set on one register
   task automatic sweep_register(input logic want_gain, input logic [BTN_W-1:0] press,
                                 input int presses);
      set_edit_target(want_gain);
      repeat (presses) begin
         send_request(make_request(press, $urandom_range(1023), $urandom_range(1023)));
         send_request(make_request(LV_NONE, $urandom_range(1023), $urandom_range(1023)));
      end
   endtask

   // Sample extremes, balance point and alternating bit patterns
   task automatic test_reset_outputs();
      send_request(make_request(LV_NONE, 0, 0));
      send_request(make_request(LV_NONE, 1023, 1023));
      send_request(make_request(LV_NONE, 456, 'h155));
      send_request(make_request(LV_NONE, 455, 'h2AA));
   endtask

   // Every button, held buttons, simultaneous edges, both edit targets
   task automatic test_button_edges();
      logic [BTN_W-1:0] seq[15];
      seq = '{LV_UP, LV_UP, LV_NONE, LV_DOWN, LV_NONE, LV_FINE, LV_FINE, LV_NONE,
              LV_TOGGLE, LV_NONE, LV_UP, LV_DOWN | LV_FINE, LV_NONE,
              LV_UP | LV_DOWN | LV_FINE | LV_TOGGLE, LV_NONE};
      foreach (seq[i]) begin
         send_request(make_request(seq[i], $urandom_range(470, 450), $urandom_range(1023)));
      end
   endtask

   // Random button activity, samples mostly near the balance point
   task automatic test_mixed_random(input int count);
      logic [BTN_W-1:0] levels;
      int               pick;
      int               temp_raw;
      int               cooler_raw;
      repeat (count) begin
         levels = sent_levels;
         for (int b = 0; b < BTN_W; b++) begin
            if ($urandom_range(99) < 35) begin
               levels[b] = ~levels[b];
            end
         end
         if ($urandom_range(9) == 0) begin
            levels = BTN_W'($urandom);
         end
         pick = $urandom_range(99);
         if (pick < 50) begin
            temp_raw = $urandom_range(475, 440);
         end else if (pick < 65) begin
            temp_raw = $urandom_range(1) ? 1023 : 0;
         end else begin
            temp_raw = $urandom_range(1023);
         end
         cooler_raw = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 1023 : 0)
                                               : $urandom_range(1023);
         send_request(make_request(levels, temp_raw, cooler_raw));
      end
   endtask

   // Gain driven down past the negative limit so it wraps to positive
   task automatic test_gain_wrap();
      sweep_register(1'b1, LV_DOWN, 350);
   endtask

   // Setpoint driven up past the positive limit, then negative setpoints
   task automatic test_setpoint_wrap();
      sweep_register(1'b0, LV_UP | LV_FINE, 290);
   endtask

   initial begin
      clock                  = 1'b0;
      reset                  = 1'b1;
      req_if.valid           = 1'b0;
      req_if.btn_coarse_up   = 1'b0;
      req_if.btn_coarse_down = 1'b0;
      req_if.btn_fine_up     = 1'b0;
      req_if.btn_toggle      = 1'b0;
      req_if.temp_sample     = '0;
      req_if.cooler_sample   = '0;
      sent_levels            = LV_NONE;
      sent_gain_edit         = 1'b1;
      req_idle_pct           = 21;
      rsp_stall_pct          = 64;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_outputs();
      test_button_edges();
      test_mixed_random(250);
      req_idle_pct  = 64;
      rsp_stall_pct = 21;
      test_gain_wrap();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      test_setpoint_wrap();
      req_if.valid <= 1'b0;

      // drain the pipeline, then watch for stray results
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("[proportional_temperature_controller] OK");
      end else begin
         $display("[proportional_temperature_controller] ERROR");
      end
      $finish;
   end

endmodule

[proportional_temperature_controller.f]
rtl/ptc_pkg.sv
rtl/ptc_req_if.sv
rtl/ptc_rsp_if.sv
rtl/proportional_temperature_controller.sv
test/tb_top.sv
